// ===== design/lcd_pkg.sv =====
package lcd_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int LEN_W            = 9;

    localparam logic [7:0] STATUS_CODE  = 8'h07;
    localparam logic [7:0] CHECK_SEED   = 8'hFF;
    localparam logic [7:0] LENGTH_EXTRA = 8'd3;

    typedef enum logic [1:0] {
        KIND_FRAME        = 2'd0,
        KIND_BAD_LENGTH   = 2'd1,
        KIND_BAD_CHECKSUM = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PARSE,
        S_SCAN,
        S_JUDGE,
        S_EMIT
    } t_state;

    // per-cycle control shared by every cell of the row
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== design/lcd_cell.sv =====
module lcd_cell
    import lcd_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_sel,
    input  logic [7:0] i_next,
    input  logic [7:0] i_din,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift) begin
            n_byte = i_next;
        end else if (i_ctl.load && i_sel) begin
            n_byte = i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

// ===== design/length_checksum_deframer.sv =====
// Length/checksum deframer. Received bytes are taken one transaction at a time
// into a row of BUFFER_DEPTH byte cells; the front cell always holds the oldest
// byte and a shift moves every byte one cell toward the front, the front byte
// wrapping to the back. After each byte the row is parsed: the front byte plus
// 3 is the frame length; a length above BUFFER_DEPTH reports the front byte as
// a bad-length drop, an incomplete frame ends the parse, otherwise the checksum
// is walked by rotating the whole row once, after which the front byte is
// dropped as a bad checksum or the frame is sent out one byte per cycle while
// the output is not stalled. A new byte is taken only in the idle state, once
// every parse step triggered by the last byte is done. Results leave through a
// one-entry output register, and a stalled output pauses the parse in place.
module length_checksum_deframer
    import lcd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_byte_value,
    output logic       o_is_status,
    output logic       o_last
);

    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int IW = $clog2(BUFFER_DEPTH);

    t_state         r_state, n_state;
    logic [FW-1:0]  r_fill, n_fill;
    logic [IW-1:0]  r_scan, n_scan;
    logic [7:0]     r_check, n_check;
    logic           r_ok, n_ok;
    logic           r_status, n_status;
    logic [LEN_W-1:0] r_left, n_left;

    logic           r_out_valid, n_out_valid;
    t_kind          r_out_kind, n_out_kind;
    logic [7:0]     r_out_byte, n_out_byte;
    logic           r_out_status, n_out_status;
    logic           r_out_last, n_out_last;

    t_cell_ctl      w_ctl;
    logic [7:0]     w_byte [BUFFER_DEPTH];
    logic [IW-1:0]  w_wr_idx;
    logic           w_full;
    logic           w_slot_free;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_fill_ext;
    logic [LEN_W-1:0] w_scan_ext;

    for (genvar g = 0; g < BUFFER_DEPTH; g++) begin : g_cell
        lcd_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_sel  (w_wr_idx == IW'(g)),
            .i_next (w_byte[(g + 1) % BUFFER_DEPTH]),
            .i_din  (i_rx_byte),
            .o_byte (w_byte[g])
        );
    end

    assign w_full      = (r_fill == FW'(BUFFER_DEPTH));
    assign w_wr_idx    = w_full ? '0 : r_fill[IW-1:0];
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_len       = {1'b0, w_byte[0]} + LEN_W'(LENGTH_EXTRA);
    assign w_fill_ext  = LEN_W'(r_fill);
    assign w_scan_ext  = LEN_W'(r_scan);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_scan       = r_scan;
        n_check      = r_check;
        n_ok         = r_ok;
        n_status     = r_status;
        n_left       = r_left;
        n_out_valid  = r_out_valid && i_stall;
        n_out_kind   = r_out_kind;
        n_out_byte   = r_out_byte;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_ctl        = '0;
        o_stall      = 1'b1;

        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    w_ctl.load = 1'b1;
                    n_fill     = (w_full ? '0 : r_fill) + FW'(1);
                    n_state    = S_PARSE;
                end
            end
            S_PARSE: begin
                if (r_fill == '0) begin
                    n_state = S_IDLE;
                end else if (w_len > LEN_W'(BUFFER_DEPTH)) begin
                    if (w_slot_free) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_BAD_LENGTH;
                        n_out_byte   = w_byte[0];
                        n_out_status = 1'b0;
                        n_out_last   = 1'b1;
                        w_ctl.shift  = 1'b1;
                        n_fill       = r_fill - FW'(1);
                    end
                end else if (w_fill_ext < w_len) begin
                    n_state = S_IDLE;
                end else begin
                    n_scan  = '0;
                    n_check = CHECK_SEED;
                    n_ok    = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // one full rotation: the front cell shows byte r_scan of the frame
                w_ctl.shift = 1'b1;
                if (w_scan_ext < r_left) begin
                    n_check = r_check - w_byte[0];
                end
                if (w_scan_ext == r_left) begin
                    n_ok = (w_byte[0] == r_check);
                end
                n_scan = r_scan + IW'(1);
                if (r_scan == IW'(BUFFER_DEPTH - 1)) begin
                    n_state = S_JUDGE;
                end
            end
            S_JUDGE: begin
                if (!r_ok) begin
                    if (w_slot_free) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_BAD_CHECKSUM;
                        n_out_byte   = w_byte[0];
                        n_out_status = 1'b0;
                        n_out_last   = 1'b1;
                        w_ctl.shift  = 1'b1;
                        n_fill       = r_fill - FW'(1);
                        n_state      = S_PARSE;
                    end
                end else begin
                    n_status = (w_byte[1] == STATUS_CODE);
                    n_left   = w_len;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_FRAME;
                    n_out_byte   = w_byte[0];
                    n_out_status = r_status;
                    n_out_last   = (r_left == LEN_W'(1));
                    w_ctl.shift  = 1'b1;
                    n_fill       = r_fill - FW'(1);
                    n_left       = r_left - LEN_W'(1);
                    if (r_left == LEN_W'(1)) begin
                        n_state = S_PARSE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // during the scan r_left carries the index of the checksum byte
        if (r_state == S_PARSE && n_state == S_SCAN) begin
            n_left = w_len - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_check      <= n_check;
        r_ok         <= n_ok;
        r_status     <= n_status;
        r_left       <= n_left;
        r_out_kind   <= n_out_kind;
        r_out_byte   <= n_out_byte;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_byte_value = r_out_byte;
    assign o_is_status  = r_out_status;
    assign o_last       = r_out_last;

endmodule

// ===== test/length_checksum_deframer_test.sv =====
`timescale 1ns / 1ps

module length_checksum_deframer_test;
    import lcd_pkg::*;

    localparam int DEPTH          = BUFFER_DEPTH_DEF;
    localparam int RX_ITEMS       = 320;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 4 * DEPTH + 20;
    localparam int MAX_BODY       = DEPTH - int'(LENGTH_EXTRA);

    typedef struct {
        t_kind      kind;
        logic [7:0] value;
        logic       is_status;
        logic       last;
    } t_out_byte;

    class deframe_scoreboard;
        logic [7:0] rx_store [DEPTH];
        int         rx_fill;
        t_out_byte  awaited [$];
        int         errors;
        int         seen [3];

        function new();
            rx_fill = 0;
            errors  = 0;
            foreach (seen[k]) seen[k] = 0;
        endfunction

        function void await_byte(t_kind kind, logic [7:0] value, logic st, logic last);
            t_out_byte e;
            e.kind      = kind;
            e.value     = value;
            e.is_status = st;
            e.last      = last;
            awaited.push_back(e);
        endfunction

        function void drop_front(int n);
            if (n >= rx_fill) begin
                rx_fill = 0;
                return;
            end
            for (int i = 0; i < rx_fill - n; i++) rx_store[i] = rx_store[i + n];
            rx_fill -= n;
        endfunction

        // work out every output transaction caused by one received byte
        function void note_rx_byte(logic [7:0] b);
            int         flen;
            logic [7:0] chk;
            logic       st;
            if (rx_fill >= DEPTH) rx_fill = 0;
            rx_store[rx_fill] = b;
            rx_fill++;
            while (rx_fill >= 1) begin
                flen = int'(rx_store[0]) + int'(LENGTH_EXTRA);
                if (flen > DEPTH) begin
                    await_byte(KIND_BAD_LENGTH, rx_store[0], 1'b0, 1'b1);
                    drop_front(1);
                    continue;
                end
                if (rx_fill < flen) break;
                chk = CHECK_SEED;
                for (int i = 0; i < flen - 1; i++) chk = chk - rx_store[i];
                if (rx_store[flen - 1] != chk) begin
                    // resync by one byte
                    await_byte(KIND_BAD_CHECKSUM, rx_store[0], 1'b0, 1'b1);
                    drop_front(1);
                    continue;
                end
                st = (rx_store[1] == STATUS_CODE);
                for (int i = 0; i < flen; i++)
                    await_byte(KIND_FRAME, rx_store[i], st, i == flen - 1);
                drop_front(flen);
            end
        endfunction

        function void check_out_byte(t_kind kind, logic [7:0] value, logic st, logic last);
            t_out_byte e;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected output kind %0d value %02h status %0d last %0d",
                         $time, kind, value, st, last);
                return;
            end
            e = awaited.pop_front();
            if (e.kind !== kind || e.value !== value || e.is_status !== st
                    || e.last !== last) begin
                errors++;
                $display({"%0t: expected kind %0d value %02h status %0d last %0d,",
                          " got kind %0d value %02h status %0d last %0d"},
                         $time, e.kind, e.value, e.is_status, e.last,
                         kind, value, st, last);
            end else begin
                seen[int'(kind)]++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_byte_value;
    logic       o_is_status;
    logic       o_last;

    deframe_scoreboard board;
    int rx_sent     = 0;
    int rx_hold     = 0;
    int idle_cycles = 0;
    bit tx_burst    = 1'b0;
    bit rx_burst    = 1'b0;

    length_checksum_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_byte_value(o_byte_value),
        .o_is_status (o_is_status),
        .o_last      (o_last)
    );

    always #2 i_clk = ~i_clk;

    // sink side: check each transaction, then hold off for a random count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold = 0;
        end else begin
            if (o_valid && !i_stall) begin
                board.check_out_byte(t_kind'(o_kind), o_byte_value, o_is_status, o_last);
                if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
                rx_hold = rx_burst ? 0 : $urandom_range(0, 6);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            i_stall <= (rx_hold > 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        board.note_rx_byte(b);
        rx_sent++;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // length byte, second byte, body, then checksum (optionally spoiled)
    task automatic send_frame(input int body, input bit status, input bit corrupt);
        logic [7:0] fb [$];
        logic [7:0] chk;
        fb.push_back(8'(body));
        fb.push_back(status ? STATUS_CODE : 8'($urandom_range(0, 255)));
        for (int i = 0; i < body; i++) fb.push_back(8'($urandom_range(0, 255)));
        chk = CHECK_SEED;
        foreach (fb[i]) chk = chk - fb[i];
        if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
        fb.push_back(chk);
        foreach (fb[i]) send_byte(fb[i]);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int  pick;
        int  body;
        bit  paused;
        board  = new();
        paused = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: length limits, shortest frame, status frame, bad checksum
        send_byte(8'hFF);
        send_byte(8'(MAX_BODY + 1));
        send_frame(0, 1'b0, 1'b0);
        send_frame(1, 1'b1, 1'b0);
        send_frame(0, 1'b0, 1'b1);
        send_frame(2, 1'b1, 1'b1);
        send_byte(8'h00);
        send_frame(2, 1'b0, 1'b0);
        wait_drained();

        send_frame(MAX_BODY, 1'b1, 1'b0);
        while (rx_sent < RX_ITEMS) begin
            if ($urandom_range(0, 7) == 0) tx_burst = !tx_burst;
            if (!paused && rx_sent >= RX_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            body = ($urandom_range(0, 9) == 0) ? $urandom_range(6, MAX_BODY)
                                               : $urandom_range(0, 5);
            if (pick < 70)
                send_frame(body, $urandom_range(0, 3) == 0, 1'b0);
            else if (pick < 85)
                send_frame(body, $urandom_range(0, 3) == 0, 1'b1);
            else
                send_byte(8'($urandom_range(0, 255)));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d bytes as good, spoiled and stray frames with random pacing",
                 rx_sent);
        $display("checked %0d frame bytes, %0d length drops, %0d checksum drops",
                 board.seen[int'(KIND_FRAME)], board.seen[int'(KIND_BAD_LENGTH)],
                 board.seen[int'(KIND_BAD_CHECKSUM)]);
        if (board.errors == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
